// File: hdl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// plain assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/frt_pkg.sv
//------------------------------------------------------------------------------
// frt_pkg
// constants and types shared by the fragment reassembly tracker
//------------------------------------------------------------------------------
`default_nettype none
package frt_pkg;
    localparam int SLOT_COUNT        = 8;
    localparam int MAX_FRAGMENTS     = 64;
    localparam int CHUNK_BYTES       = 256;
    localparam int MAX_MESSAGE_BYTES = 16384;

    localparam logic [31:0] TIMEOUT_RESET = 32'd5000;
    localparam logic [14:0] MAXMSG_RESET  = 15'd16384;

    localparam logic [1:0] ST_PENDING  = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;

    localparam logic OP_FEED   = 1'b0;
    localparam logic OP_EXPIRE = 1'b1;

    // register indexes
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_MAXMSG  = 1'b1;

    typedef struct packed {
        logic [1:0]  status;
        logic        store_chunk;
        logic [2:0]  slot_index;
        logic [13:0] byte_offset;
        logic [8:0]  write_len;
        logic [14:0] total_len;
        logic [7:0]  expired_mask;
    } t_result;
endpackage
`default_nettype wire

// File: hdl/fragment_reassembly_tracker.sv
//------------------------------------------------------------------------------
// fragment_reassembly_tracker
// tracks message fragments in a table of reassembly slots
//------------------------------------------------------------------------------
//  channel | signals                 | direction
//  input   | i_valid / o_ready       | one header or expire beat in
//  output  | o_valid / i_ready       | one result beat out
//  config  | apb psel..pready        | timeout_ms at 0x0, max_message_bytes at 0x4
//
//  a feed beat holds off the next accept until its result moves out: it passes a start
//  register, a scan of the single-read-port slot memory, then decide, read, update,
//  done and the move into the output register
//  expire and invalid beats skip the read-modify-write
//  a full output register holds the result in the engine and blocks the input
//  reset is synchronous, active low; clears slot valid bits, not the memory
`default_nettype none
module fragment_reassembly_tracker #(
    parameter int SLOT_COUNT        = frt_pkg::SLOT_COUNT,
    parameter int MAX_FRAGMENTS     = frt_pkg::MAX_FRAGMENTS,
    parameter int CHUNK_BYTES       = frt_pkg::CHUNK_BYTES,
    parameter int MAX_MESSAGE_BYTES = frt_pkg::MAX_MESSAGE_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_op,
    input  wire logic [47:0] i_now_ms,
    input  wire logic [15:0] i_message_id,
    input  wire logic [15:0] i_fragment_index,
    input  wire logic [15:0] i_fragment_count,
    input  wire logic [15:0] i_chunk_len,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic             o_store_chunk,
    output logic [2:0]       o_slot_index,
    output logic [13:0]      o_byte_offset,
    output logic [8:0]       o_write_len,
    output logic [14:0]      o_total_len,
    output logic [7:0]       o_expired_mask,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    `include "assert_macros.svh"

    logic [31:0] r_timeout;
    logic [14:0] r_maxmsg;
    logic        r_busy;
    logic        r_op;
    logic [47:0] r_now;
    logic [15:0] r_id, r_fidx, r_fcnt, r_clen;
    logic        r_ovalid;
    logic        r_start;
    logic        r_hold;
    frt_pkg::t_result r_out;

    logic        w_accept;
    logic        w_move;
    logic        w_out_inv;
    logic        w_bad, w_last, w_eng_busy, w_done;
    frt_pkg::t_result w_res;

    assign pready    = 1'b1;
    assign w_accept  = i_valid && o_ready;
    assign o_ready   = i_rst_n && !r_busy;
    // engine result moves into the output register once it is free
    assign w_move    = (w_done || r_hold) && (!r_ovalid || i_ready);
    assign w_out_inv = o_valid && (o_status == frt_pkg::ST_INVALID);

    always_comb begin
        unique case (paddr[2])
            frt_pkg::REG_TIMEOUT: prdata = r_timeout;
            frt_pkg::REG_MAXMSG:  prdata = {17'd0, r_maxmsg};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= frt_pkg::TIMEOUT_RESET;
            r_maxmsg  <= frt_pkg::MAXMSG_RESET;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
            if (paddr[2] == frt_pkg::REG_TIMEOUT) r_timeout <= pwdata;
            else r_maxmsg <= pwdata[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_op; r_now <= i_now_ms; r_id <= i_message_id;
            r_fidx <= i_fragment_index; r_fcnt <= i_fragment_count;
            r_clen <= i_chunk_len;
        end
        if (w_move) r_out <= w_res;
    end

    // busy covers the engine run; output register parts the result side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_hold   <= 1'b0;
        end else begin
            if (w_accept) r_busy <= 1'b1;
            else if (w_move) r_busy <= 1'b0;
            if (w_move) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            // engine result waits while output full
            r_hold <= (w_done || r_hold) && !w_move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
        end else begin
            r_start <= w_accept;
        end
    end

    frt_check #(
        .MAX_FRAGMENTS(MAX_FRAGMENTS), .CHUNK_BYTES(CHUNK_BYTES),
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_check (
        .i_clk(i_clk), .i_fragment_index(i_fragment_index),
        .i_fragment_count(i_fragment_count), .i_chunk_len(i_chunk_len),
        .i_max_message_bytes(r_maxmsg), .i_load(w_accept),
        .o_bad(w_bad), .o_last(w_last)
    );

    frt_engine #(
        .SLOT_COUNT(SLOT_COUNT), .MAX_FRAGMENTS(MAX_FRAGMENTS),
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_op(r_op), .i_now_ms(r_now), .i_message_id(r_id),
        .i_fragment_index(r_fidx), .i_fragment_count(r_fcnt),
        .i_chunk_len(r_clen), .i_timeout_ms(r_timeout),
        .i_bad(w_bad), .i_last(w_last),
        .o_busy(w_eng_busy), .o_done(w_done), .o_result(w_res)
    );

    assign o_valid        = r_ovalid;
    assign o_status       = r_out.status;
    assign o_store_chunk  = r_out.store_chunk;
    assign o_slot_index   = r_out.slot_index;
    assign o_byte_offset  = r_out.byte_offset;
    assign o_write_len    = r_out.write_len;
    assign o_total_len    = r_out.total_len;
    assign o_expired_mask = r_out.expired_mask;

    `ASSERT_CLK(a_no_accept_busy, i_clk, i_rst_n, w_eng_busy |-> !w_accept, "accept while busy")
    `ASSERT_CLK(a_done_in_run, i_clk, i_rst_n, w_done |-> r_busy, "done without beat")
    `ASSERT_CLK(a_invalid_clean, i_clk, i_rst_n, w_out_inv |-> !o_store_chunk, "invalid stores")
    `ASSERT_CLK(a_hold_full, i_clk, i_rst_n, r_hold |-> o_valid, "hold with output empty")
endmodule
`default_nettype wire

// File: hdl/frt_check.sv
//------------------------------------------------------------------------------
// frt_check
// header validation for one fragment, registered into the engine
//------------------------------------------------------------------------------
`default_nettype none
module frt_check #(
    parameter int MAX_FRAGMENTS     = frt_pkg::MAX_FRAGMENTS,
    parameter int CHUNK_BYTES       = frt_pkg::CHUNK_BYTES,
    parameter int MAX_MESSAGE_BYTES = frt_pkg::MAX_MESSAGE_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic [15:0] i_fragment_index,
    input  wire logic [15:0] i_fragment_count,
    input  wire logic [15:0] i_chunk_len,
    input  wire logic [14:0] i_max_message_bytes,
    input  wire logic        i_load,
    output logic             o_bad,
    output logic             o_last
);
    logic [47:0] w_total;
    logic        w_last;
    logic        n_bad;
    logic        r_bad;
    logic        r_last;

    always_comb begin
        w_total = 48'(i_fragment_count) * 48'(CHUNK_BYTES);
        w_last  = (17'(i_fragment_index) + 17'd1) == 17'(i_fragment_count);
        n_bad = (i_fragment_count == 16'd0)
             || (32'(i_fragment_count) > 32'(MAX_FRAGMENTS))
             || (i_fragment_index >= i_fragment_count)
             || (32'(i_chunk_len) > 32'(CHUNK_BYTES))
             || (w_total > 48'(i_max_message_bytes))
             || (w_total > 48'(MAX_MESSAGE_BYTES))
             || (!w_last && (32'(i_chunk_len) != 32'(CHUNK_BYTES)))
             || (w_last && (i_fragment_count > 16'd1) && (i_chunk_len == 16'd0));
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bad  <= n_bad;
            r_last <= w_last;
        end
    end

    assign o_bad  = r_bad;
    assign o_last = r_last;
endmodule
`default_nettype wire

// File: hdl/frt_engine.sv
//------------------------------------------------------------------------------
// frt_engine
// slot table in one memory, scanned one entry a cycle, then modified
//------------------------------------------------------------------------------
`default_nettype none
module frt_engine #(
    parameter int SLOT_COUNT    = frt_pkg::SLOT_COUNT,
    parameter int MAX_FRAGMENTS = frt_pkg::MAX_FRAGMENTS,
    parameter int CHUNK_BYTES   = frt_pkg::CHUNK_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_op,
    input  wire logic [47:0] i_now_ms,
    input  wire logic [15:0] i_message_id,
    input  wire logic [15:0] i_fragment_index,
    input  wire logic [15:0] i_fragment_count,
    input  wire logic [15:0] i_chunk_len,
    input  wire logic [31:0] i_timeout_ms,
    input  wire logic        i_bad,
    input  wire logic        i_last,
    output logic             o_busy,
    output logic             o_done,
    output frt_pkg::t_result o_result
);
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int FW = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
    localparam int CW = $clog2(MAX_FRAGMENTS + 1);
    localparam int EW = 16 + CW + CW + MAX_FRAGMENTS + 1 + 15 + 48;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    typedef struct packed {
        logic [15:0]              id;
        logic [CW-1:0]            ftotal;
        logic [CW-1:0]            rtotal;
        logic [MAX_FRAGMENTS-1:0] bits;
        logic                     lknown;
        logic [14:0]              len;
        logic [47:0]              first;
    } t_entry;

    // entry payload in memory, active bits in flops (reset clears them)
    t_entry                r_mem [SLOT_COUNT];
    t_entry                r_rd;
    logic [SLOT_COUNT-1:0] r_active;

    logic [2:0]  r_state;
    logic [SW:0] r_idx;
    logic        r_rd_ok;
    logic [SW-1:0] r_rd_idx;
    logic        r_hit;
    logic [SW-1:0] r_hit_idx;
    logic        r_free;
    logic [SW-1:0] r_free_idx;
    logic        r_old_ok;
    logic [SW-1:0] r_old_idx;
    logic [47:0] r_old_time;
    logic [SLOT_COUNT-1:0] r_exp;
    logic [SW-1:0] r_slot;
    logic        r_new;
    frt_pkg::t_result r_res;
    frt_pkg::t_result n_res;

    logic          w_scan;
    logic          w_rd_en;
    logic [SW-1:0] w_rd_addr;
    logic          w_wr_en;
    logic [SW-1:0] w_wr_addr;
    t_entry        w_wr_data;
    t_entry        w_cur;
    logic [47:0]   w_age;
    logic [FW-1:0] w_fidx;
    logic [CW-1:0] w_rtot;
    logic [13:0]   w_off;
    logic [14:0]   w_len;
    logic [7:0]    w_mask;
    logic          w_mis;
    logic          w_dup;
    logic          w_cpl;

    always_comb begin
        w_scan    = (r_state == S_SCAN) && (32'(r_idx) < SLOT_COUNT);
        w_rd_en   = w_scan || r_state == S_RD;
        w_rd_addr = (r_state == S_RD) ? r_slot : r_idx[SW-1:0];
        w_age     = i_now_ms - r_rd.first;
        w_fidx    = i_fragment_index[FW-1:0];
        w_off     = 14'(32'(i_fragment_index) * CHUNK_BYTES);
        w_len     = 15'(w_off) + 15'(i_chunk_len);
        // fresh slot starts empty
        w_cur = r_rd;
        if (r_new) begin
            w_cur.ftotal = CW'(i_fragment_count);
            w_cur.rtotal = '0;
            w_cur.bits   = '0;
            w_cur.lknown = 1'b0;
            w_cur.len    = '0;
            w_cur.first  = i_now_ms;
        end
        w_cur.id = i_message_id;
        w_rtot = w_cur.rtotal + CW'(1);
        w_mis  = !r_new && (r_rd.ftotal != CW'(i_fragment_count));
        w_dup  = !r_new && r_rd.bits[w_fidx];
        w_cpl  = (w_rtot == w_cur.ftotal);
        w_wr_data = w_cur;
        w_wr_data.bits[w_fidx] = 1'b1;
        w_wr_data.rtotal = w_rtot;
        if (i_last) begin
            w_wr_data.len    = w_len;
            w_wr_data.lknown = 1'b1;
        end
        // mismatch and duplicate leave the entry untouched
        w_wr_en   = (r_state == S_UPD) && !w_mis && !w_dup;
        w_wr_addr = r_slot;
        w_mask = '0;
        for (int k = 0; k < SLOT_COUNT && k < 8; k++) w_mask[k] = r_exp[k];

        n_res = r_res;
        if (r_state == S_MOD) begin
            n_res = '0;
            if (i_op == frt_pkg::OP_EXPIRE) n_res.expired_mask = w_mask;
            else if (i_bad) n_res.status = frt_pkg::ST_INVALID;
        end else if (r_state == S_UPD) begin
            n_res = '0;
            if (w_mis) begin
                n_res.status = frt_pkg::ST_INVALID;
            end else begin
                n_res.slot_index = 3'(r_slot);
                if (!w_dup) begin
                    n_res.store_chunk = 1'b1;
                    n_res.byte_offset = w_off;
                    n_res.write_len   = 9'(i_chunk_len);
                    if (w_cpl && !(w_cur.lknown || i_last)) begin
                        n_res = '0;
                        n_res.status = frt_pkg::ST_INVALID;
                    end else if (w_cpl) begin
                        n_res.status    = frt_pkg::ST_COMPLETE;
                        n_res.total_len = i_last ? w_len : w_cur.len;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) r_rd <= r_mem[w_rd_addr];
        if (w_wr_en) r_mem[w_wr_addr] <= w_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            r_rd_ok  <= w_scan;
            r_rd_idx <= r_idx[SW-1:0];
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state    <= S_SCAN;
                        r_idx      <= '0;
                        r_hit      <= 1'b0;
                        r_free     <= 1'b0;
                        r_old_ok   <= 1'b0;
                        r_exp      <= '0;
                    end
                end
                S_SCAN: begin
                    if (32'(r_idx) < SLOT_COUNT) r_idx <= r_idx + (SW+1)'(1);
                    if (r_rd_ok) begin
                        if (i_op == frt_pkg::OP_EXPIRE) begin
                            if (r_active[r_rd_idx] && w_age > 48'(i_timeout_ms)) begin
                                r_exp[r_rd_idx]    <= 1'b1;
                                r_active[r_rd_idx] <= 1'b0;
                            end
                        end else begin
                            if (r_active[r_rd_idx] && r_rd.id == i_message_id && !r_hit) begin
                                r_hit     <= 1'b1;
                                r_hit_idx <= r_rd_idx;
                            end
                            if (!r_active[r_rd_idx] && !r_free) begin
                                r_free     <= 1'b1;
                                r_free_idx <= r_rd_idx;
                            end
                            if (!r_old_ok || r_rd.first < r_old_time) begin
                                r_old_ok   <= 1'b1;
                                r_old_idx  <= r_rd_idx;
                                r_old_time <= r_rd.first;
                            end
                        end
                    end
                    if (32'(r_idx) == SLOT_COUNT && !r_rd_ok) r_state <= S_MOD;
                end
                S_MOD: begin
                    r_res <= n_res;
                    if (i_op == frt_pkg::OP_EXPIRE || i_bad) begin
                        r_state <= S_DONE;
                    end else begin
                        r_slot  <= r_hit ? r_hit_idx : (r_free ? r_free_idx : r_old_idx);
                        r_new   <= !r_hit;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_state <= S_DONE;
                    r_res   <= n_res;
                    if (!w_mis && !w_dup) r_active[r_slot] <= !w_cpl;
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // mismatch must not write: guard write enable
    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_result = r_res;
endmodule
`default_nettype wire

// File: dv/fragment_reassembly_tracker_test.sv
//------------------------------------------------------------------------------
// fragment_reassembly_tracker_test
// drives fragment headers and expire beats into the reassembly tracker,
// predicts every result from a local copy of the slot table and compares
// each field of each result beat in order
//------------------------------------------------------------------------------
`default_nettype none
module fragment_reassembly_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_op = frt_pkg::OP_FEED;
    logic [47:0] i_now_ms = '0;
    logic [15:0] i_message_id = '0;
    logic [15:0] i_fragment_index = '0;
    logic [15:0] i_fragment_count = '0;
    logic [15:0] i_chunk_len = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic        o_store_chunk;
    logic [2:0]  o_slot_index;
    logic [13:0] o_byte_offset;
    logic [8:0]  o_write_len;
    logic [14:0] o_total_len;
    logic [7:0]  o_expired_mask;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fragment_reassembly_tracker DUT (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // local copy of the slot table
    logic        tbl_active [frt_pkg::SLOT_COUNT];
    logic [15:0] tbl_id     [frt_pkg::SLOT_COUNT];
    logic [6:0]  tbl_frags  [frt_pkg::SLOT_COUNT];
    logic [6:0]  tbl_got    [frt_pkg::SLOT_COUNT];
    logic [63:0] tbl_bits   [frt_pkg::SLOT_COUNT];
    logic        tbl_lknown [frt_pkg::SLOT_COUNT];
    logic [14:0] tbl_len    [frt_pkg::SLOT_COUNT];
    logic [47:0] tbl_first  [frt_pkg::SLOT_COUNT];
    logic [31:0] cfg_timeout = frt_pkg::TIMEOUT_RESET;
    logic [14:0] cfg_maxmsg  = frt_pkg::MAXMSG_RESET;

    frt_pkg::t_result pending_results[$];
    int      errors = 0;
    int      beats_in = 0;
    int      beats_out = 0;
    int      completions = 0;
    int      expiries = 0;
    int      cycle_count = 0;
    bit      hold_off = 1'b0;
    bit      rx_busy = 1'b1;
    bit      tx_busy = 1'b1;
    logic [47:0] clock_ms = 48'd100;

    function automatic frt_pkg::t_result predict_feed(logic [47:0] now, logic [15:0] id,
                                                      logic [15:0] idx, logic [15:0] cnt,
                                                      logic [15:0] clen);
        frt_pkg::t_result r;
        int      s;
        bit      last;
        logic [31:0] total;
        r = '0;
        r.status = frt_pkg::ST_INVALID;
        s = -1;
        total = cnt * frt_pkg::CHUNK_BYTES;
        last = (32'(idx) + 1 == 32'(cnt));
        if (cnt == 0 || cnt > frt_pkg::MAX_FRAGMENTS || idx >= cnt ||
            clen > frt_pkg::CHUNK_BYTES || total > cfg_maxmsg ||
            total > frt_pkg::MAX_MESSAGE_BYTES ||
            (!last && clen != frt_pkg::CHUNK_BYTES) || (last && cnt > 1 && clen == 0))
            return r;
        for (int i = frt_pkg::SLOT_COUNT - 1; i >= 0; i--)
            if (tbl_active[i] && tbl_id[i] == id) s = i;
        if (s >= 0) begin
            if (tbl_frags[s] != cnt) return r;
        end else begin
            for (int i = frt_pkg::SLOT_COUNT - 1; i >= 0; i--)
                if (!tbl_active[i]) s = i;
            if (s < 0) begin
                s = 0;
                for (int i = 1; i < frt_pkg::SLOT_COUNT; i++)
                    if (tbl_first[i] < tbl_first[s]) s = i;
            end
            tbl_active[s] = 1'b1;
            tbl_id[s]     = id;
            tbl_frags[s]  = cnt[6:0];
            tbl_got[s]    = '0;
            tbl_bits[s]   = '0;
            tbl_lknown[s] = 1'b0;
            tbl_len[s]    = '0;
            tbl_first[s]  = now;
        end
        r.slot_index = s[2:0];
        r.status = frt_pkg::ST_PENDING;
        if (tbl_bits[s][idx[5:0]]) return r;
        tbl_bits[s][idx[5:0]] = 1'b1;
        tbl_got[s]++;
        if (last) begin
            tbl_len[s] = 15'(idx * frt_pkg::CHUNK_BYTES + clen);
            tbl_lknown[s] = 1'b1;
        end
        if (tbl_got[s] == tbl_frags[s]) begin
            tbl_active[s] = 1'b0;
            if (!tbl_lknown[s]) begin
                r = '0;
                r.status = frt_pkg::ST_INVALID;
                return r;
            end
            r.status = frt_pkg::ST_COMPLETE;
            r.total_len = tbl_len[s];
        end
        r.store_chunk = 1'b1;
        r.byte_offset = 14'(idx * frt_pkg::CHUNK_BYTES);
        r.write_len = clen[8:0];
        return r;
    endfunction

    function automatic frt_pkg::t_result predict_expire(logic [47:0] now);
        frt_pkg::t_result r;
        r = '0;
        for (int i = 0; i < frt_pkg::SLOT_COUNT; i++)
            if (tbl_active[i] && 48'(now - tbl_first[i]) > cfg_timeout) begin
                tbl_active[i] = 1'b0;
                r.expired_mask[i] = 1'b1;
            end
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $realtime,
                     pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stalls, optional long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off)
            i_ready <= 1'b0;
        else if (!rx_busy)
            i_ready <= 1'b1;
        else
            i_ready <= ($urandom_range(99) >= 28);
    end

    // result checker
    always @(posedge i_clk) begin
        frt_pkg::t_result got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_status, o_store_chunk, o_slot_index, o_byte_offset, o_write_len,
                   o_total_len, o_expired_mask};
            beats_out++;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result beat %p", $realtime, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.status == frt_pkg::ST_COMPLETE) completions++;
                if (got.expired_mask != 0) expiries++;
                if (got !== want) begin
                    errors++;
                    $display("%0t mismatch: expected %p actual %p", $realtime, want, got);
                end
            end
        end
    end

    task automatic send_beat(logic op, logic [47:0] now, logic [15:0] id,
                             logic [15:0] idx, logic [15:0] cnt, logic [15:0] clen);
        @(negedge i_clk);
        while (tx_busy && $urandom_range(99) < 28) @(negedge i_clk);
        i_valid <= 1'b1;
        i_op <= op;
        i_now_ms <= now;
        i_message_id <= id;
        i_fragment_index <= idx;
        i_fragment_count <= cnt;
        i_chunk_len <= clen;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (op == frt_pkg::OP_EXPIRE) pending_results.push_back(predict_expire(now));
        else pending_results.push_back(predict_feed(now, id, idx, cnt, clen));
        beats_in++;
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic send_fragment(logic [15:0] id, logic [15:0] idx, logic [15:0] cnt,
                                 logic [15:0] clen);
        clock_ms = clock_ms + $urandom_range(40);
        send_beat(frt_pkg::OP_FEED, clock_ms, id, idx, cnt, clen);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        while (guard < 40) begin
            @(posedge i_clk);
            guard++;
        end
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == 3'd0) cfg_timeout = value;
        else cfg_maxmsg = value[14:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // whole message, fragments shuffled, sometimes with a duplicate
    task automatic send_message(logic [15:0] id, int cnt, bit dup);
        int order[$];
        int lastlen;
        for (int i = 0; i < cnt; i++) order.push_back(i);
        order.shuffle();
        if (dup) order.insert($urandom_range(order.size()), $urandom_range(cnt - 1));
        lastlen = $urandom_range(frt_pkg::CHUNK_BYTES, cnt > 1 ? 1 : 0);
        foreach (order[k])
            send_fragment(id, 16'(order[k]), 16'(cnt),
                          16'(order[k] == cnt - 1 ? lastlen : frt_pkg::CHUNK_BYTES));
    endtask

    task automatic test_directed();
        send_fragment(16'h0000, 0, 1, 0);              // single fragment, empty
        send_fragment(16'hFFFF, 0, 1, frt_pkg::CHUNK_BYTES);
        send_fragment(16'h1234, 0, 0, 10);             // zero count
        send_fragment(16'h1234, 0, 65, 256);           // too many fragments
        send_fragment(16'h1234, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_fragment(16'h1234, 3, 3, 10);             // index past count
        send_fragment(16'h1234, 1, 2, 300);            // chunk too long
        send_fragment(16'h1234, 0, 2, 100);            // short non-last chunk
        send_fragment(16'h1234, 1, 2, 0);              // empty last chunk
        send_fragment(16'h0042, 0, 64, 256);
        send_fragment(16'h0042, 0, 64, 256);           // duplicate
        send_fragment(16'h0042, 1, 63, 256);           // count mismatch
        send_fragment(16'h0042, 63, 64, 1);
        for (int i = 0; i < 9; i++) send_fragment(16'(16'h0100 + i), 0, 2, 256); // eviction
        send_beat(frt_pkg::OP_EXPIRE, clock_ms + 48'd100000, 0, 0, 0, 0);
        send_beat(frt_pkg::OP_EXPIRE, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0);
        drain();
    endtask

    task automatic test_config_limits();
        write_reg(3'd4, 32'd1);              // nothing fits
        send_fragment(16'h0007, 0, 1, 1);
        write_reg(3'd4, 32'd512);
        send_fragment(16'h0008, 0, 3, 256);
        send_message(16'h0009, 2, 0);
        write_reg(3'd0, 32'd0);
        send_fragment(16'h000A, 0, 2, 256);
        send_beat(frt_pkg::OP_EXPIRE, clock_ms, 0, 0, 0, 0);  // age zero, not expired
        send_beat(frt_pkg::OP_EXPIRE, clock_ms + 48'd1, 0, 0, 0, 0);
        send_fragment(16'h000B, 0, 2, 256);
        send_beat(frt_pkg::OP_EXPIRE, clock_ms - 48'd1, 0, 0, 0, 0); // time backwards
        write_reg(3'd0, 32'hFFFF_FFFF);
        write_reg(3'd4, 32'd16384);
        drain();
    endtask

    task automatic test_random(int beats);
        int count;
        count = 0;
        while (count < beats) begin
            case ($urandom_range(9))
                0: begin
                    send_beat(frt_pkg::OP_EXPIRE, $urandom_range(3) == 0 ?
                              48'({$urandom, $urandom}) : clock_ms, 0, 0, 0, 0);
                    count++;
                end
                1, 2: begin
                    send_beat(frt_pkg::OP_FEED, 48'({$urandom, $urandom}), 16'($urandom),
                              16'($urandom_range(70)), 16'($urandom_range(70)),
                              16'($urandom_range(260)));
                    count++;
                end
                default: begin
                    int cnt;
                    cnt = ($urandom_range(9) == 0) ? $urandom_range(64, 1) :
                                                     $urandom_range(6, 1);
                    send_message(16'($urandom_range(15)), cnt, $urandom_range(3) == 0);
                    count += cnt;
                end
            endcase
        end
        drain();
    endtask

    task automatic test_backpressure();
        int cycles;
        hold_off = 1'b1;
        fork
            for (int i = 0; i < 12; i++) send_fragment(16'(16'h0200 + i), 0, 1, 16'(i));
            begin
                cycles = 0;
                while (cycles < 300) begin
                    @(posedge i_clk);
                    cycles++;
                end
                hold_off = 1'b0;
            end
        join
        drain();
    endtask

    task automatic test_timeouts();
        write_reg(3'd0, 32'd200);
        test_random(250);
        write_reg(3'd0, frt_pkg::TIMEOUT_RESET);
        write_reg(3'd4, 32'd2048);
        test_random(150);
        write_reg(3'd4, 32'd16384);
    endtask

    initial begin
        for (int i = 0; i < frt_pkg::SLOT_COUNT; i++) begin
            tbl_active[i] = 1'b0;
            tbl_id[i] = '0;
            tbl_frags[i] = '0;
            tbl_got[i] = '0;
            tbl_bits[i] = '0;
            tbl_lknown[i] = 1'b0;
            tbl_len[i] = '0;
            tbl_first[i] = '0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_config_limits();
        test_backpressure();
        rx_busy = 1'b0;
        tx_busy = 1'b0;
        test_random(100);    // no idling on either side
        rx_busy = 1'b1;
        tx_busy = 1'b1;
        test_random(450);
        test_timeouts();
        drain();
        $display("%0d beats in, %0d results, %0d completed messages, %0d expiries",
                 beats_in, beats_out, completions, expiries);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+hdl
hdl/frt_pkg.sv
hdl/frt_check.sv
hdl/frt_engine.sv
hdl/fragment_reassembly_tracker.sv
dv/fragment_reassembly_tracker_test.sv
